// ===== hdl/leb128_stream_decoder_core_macros.svh =====
// assertion macros for the leb128 stream decoder
// used by leb128_stream_decoder_core, expects i_clk and i_rst_n in scope
`ifndef LEB128_STREAM_DECODER_CORE_MACROS_SVH
`define LEB128_STREAM_DECODER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define LEB_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("leb128 decoder: same-cycle check failed");
`define LEB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("leb128 decoder: next-cycle check failed");
`else
`define LEB_ASSERT_IMPLY(lbl, ante, cons)
`define LEB_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hdl/leb_pkg.sv =====
// shared types, command codes and helpers for the leb128 stream decoder
// no dependencies
package leb_pkg;

    localparam int VALUE_W   = 64;
    localparam int SHIFT_W   = 7;
    localparam int PAYLOAD_W = 7;

    // shift saturates here once a number runs past 64 bits
    localparam logic [SHIFT_W-1:0] SHIFT_CAP  = 7'd70;
    localparam logic [SHIFT_W-1:0] SHIFT_STEP = 7'd7;

    // command kinds passed from front to back
    localparam logic [1:0] CMD_END  = 2'd0;
    localparam logic [1:0] CMD_CONT = 2'd1;
    localparam logic [1:0] CMD_LAST = 2'd2;

    typedef struct packed {
        logic [1:0]           kind;
        logic [PAYLOAD_W-1:0] payload;
    } t_cmd;

    // sign extension of a finished or truncated number
    function automatic logic [VALUE_W-1:0] sign_extend(
        input logic [VALUE_W-1:0] v,
        input logic [SHIFT_W-1:0] shift,
        input logic               sign,
        input logic               signed_mode
    );
        logic [VALUE_W-1:0] res;
        res = v;
        if (signed_mode && sign && (shift != '0) && !shift[SHIFT_W-1]) begin
            res = v | ({VALUE_W{1'b1}} << shift[SHIFT_W-2:0]);
        end
        return res;
    endfunction

endpackage

// ===== hdl/leb_front.sv =====
// front stage: accepts bytes, classifies them into commands and holds one
// depends on leb_pkg
module leb_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  logic [7:0]    i_s_tdata,
    input  logic          i_s_tuser,
    output logic          o_push_valid,
    input  logic          i_push_ready,
    output leb_pkg::t_cmd o_push_data
);

    logic          r_valid;
    logic          n_valid;
    leb_pkg::t_cmd r_cmd;
    leb_pkg::t_cmd n_cmd;
    logic          w_accept;

    // stage frees up when empty or when its beat moves on
    assign o_s_tready   = !r_valid || i_push_ready;
    assign w_accept     = i_s_tvalid && o_s_tready;
    assign o_push_valid = r_valid;
    assign o_push_data  = r_cmd;

    // classify the incoming beat
    always_comb begin
        n_valid = r_valid;
        n_cmd   = r_cmd;
        if (w_accept) begin
            n_valid       = 1'b1;
            n_cmd.payload = i_s_tdata[leb_pkg::PAYLOAD_W-1:0];
            if (!i_s_tuser) begin
                n_cmd.kind = leb_pkg::CMD_END;
            end else if (i_s_tdata[7]) begin
                n_cmd.kind = leb_pkg::CMD_CONT;
            end else begin
                n_cmd.kind = leb_pkg::CMD_LAST;
            end
        end else if (i_push_ready) begin
            n_valid = 1'b0;
        end
    end

    // control register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload register
    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
    end

endmodule

// ===== hdl/leb_fifo.sv =====
// small command queue between front and back
// depends on leb_pkg
module leb_fifo #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  leb_pkg::t_cmd i_push_data,
    output logic          o_pop_valid,
    input  logic          i_pop_ready,
    output leb_pkg::t_cmd o_pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    leb_pkg::t_cmd    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;
    logic             w_push;
    logic             w_pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    // pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

// ===== hdl/leb_back.sv =====
// back stage: accumulates payloads, finishes numbers and holds the result beat
// depends on leb_pkg
module leb_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_signed_mode,
    input  logic                        i_cmd_valid,
    output logic                        o_cmd_ready,
    input  leb_pkg::t_cmd               i_cmd,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [leb_pkg::VALUE_W-1:0] o_m_tdata,
    output logic                        o_m_tuser
);

    logic [leb_pkg::VALUE_W-1:0] r_acc;
    logic [leb_pkg::SHIFT_W-1:0] r_shift;
    logic                        r_sign;
    logic                        r_out_valid;
    logic [leb_pkg::VALUE_W-1:0] r_out_value;
    logic                        r_out_mal;

    logic [leb_pkg::VALUE_W-1:0] n_acc;
    logic [leb_pkg::SHIFT_W-1:0] n_shift;
    logic                        n_sign;
    logic                        n_out_valid;
    logic [leb_pkg::VALUE_W-1:0] n_out_value;
    logic                        n_out_mal;

    logic                        w_pop;
    logic [leb_pkg::VALUE_W-1:0] w_slice;
    logic [leb_pkg::VALUE_W-1:0] w_acc_upd;
    logic [leb_pkg::SHIFT_W-1:0] w_shift_sum;
    logic [leb_pkg::SHIFT_W-1:0] w_shift_upd;
    logic                        w_overflow;

    // take a command whenever the result register can accept a beat
    assign o_cmd_ready = !r_out_valid || i_m_tready;
    assign w_pop       = i_cmd_valid && o_cmd_ready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_value;
    assign o_m_tuser  = r_out_mal;

    // payload placement and shift advance
    always_comb begin
        w_slice     = {{(leb_pkg::VALUE_W - leb_pkg::PAYLOAD_W){1'b0}}, i_cmd.payload}
                      << r_shift[leb_pkg::SHIFT_W-2:0];
        w_acc_upd   = r_shift[leb_pkg::SHIFT_W-1] ? r_acc : (r_acc | w_slice);
        w_shift_sum = r_shift + leb_pkg::SHIFT_STEP;
        w_shift_upd = (w_shift_sum > leb_pkg::SHIFT_CAP) ? leb_pkg::SHIFT_CAP : w_shift_sum;
        // unsigned number already holds ten bytes
        w_overflow  = !i_signed_mode && r_shift[leb_pkg::SHIFT_W-1];
    end

    // command execution
    always_comb begin
        n_acc       = r_acc;
        n_shift     = r_shift;
        n_sign      = r_sign;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_value = r_out_value;
        n_out_mal   = r_out_mal;
        if (w_pop) begin
            case (i_cmd.kind)
                leb_pkg::CMD_END: begin
                    n_out_valid = 1'b1;
                    n_out_value = leb_pkg::sign_extend(r_acc, r_shift, r_sign, i_signed_mode);
                    n_out_mal   = 1'b1;
                    n_acc       = '0;
                    n_shift     = '0;
                    n_sign      = 1'b0;
                end
                leb_pkg::CMD_CONT, leb_pkg::CMD_LAST: begin
                    if (w_overflow) begin
                        n_out_valid = 1'b1;
                        n_out_value = r_acc;
                        n_out_mal   = 1'b1;
                        n_acc       = '0;
                        n_shift     = '0;
                        n_sign      = 1'b0;
                    end else if (i_cmd.kind == leb_pkg::CMD_CONT) begin
                        n_acc   = w_acc_upd;
                        n_shift = w_shift_upd;
                        n_sign  = i_cmd.payload[leb_pkg::PAYLOAD_W-1];
                    end else begin
                        n_out_valid = 1'b1;
                        n_out_value = leb_pkg::sign_extend(w_acc_upd, w_shift_upd,
                                          i_cmd.payload[leb_pkg::PAYLOAD_W-1], i_signed_mode);
                        n_out_mal   = 1'b0;
                        n_acc       = '0;
                        n_shift     = '0;
                        n_sign      = 1'b0;
                    end
                end
                default: begin
                    n_acc = r_acc;
                end
            endcase
        end
    end

    // decode state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_shift     <= '0;
            r_sign      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_acc       <= n_acc;
            r_shift     <= n_shift;
            r_sign      <= n_sign;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_out_value <= n_out_value;
        r_out_mal   <= n_out_mal;
    end

endmodule

// ===== hdl/leb128_stream_decoder_core.sv =====
// top level of the leb128 stream decoder: front, command queue, back, config
// depends on leb_pkg, leb_front, leb_fifo, leb_back and the macros header
`include "leb128_stream_decoder_core_macros.svh"

// Decodes LEB128 numbers of up to 64 bits from a byte stream, one byte per
// clock cycle sustained while the output is not stalled. Each input beat
// carries a byte with tuser high, or an end-of-buffer mark with tuser low; a
// number's result beat passes through the front register, the queue and the
// result register. The front classifies bytes into commands, a QUEUE_DEPTH
// deep queue decouples it from the back, which shifts each 7-bit payload
// into the accumulator and holds the result until taken. Result tuser is
// the malformed flag (truncated, or unsigned number longer than ten bytes).
// Write signed mode only while the block is idle.
module leb128_stream_decoder_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: bit 0 signed mode
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    // byte input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] has_byte
    // decoded numbers
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [63:0] value
    output logic        m_axis_tuser    // [0] malformed
);

    logic          r_signed_mode;
    logic          w_push_valid;
    logic          w_push_ready;
    leb_pkg::t_cmd w_push_data;
    logic          w_pop_valid;
    logic          w_pop_ready;
    leb_pkg::t_cmd w_pop_data;
    logic          w_end_pop;

    // mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_signed_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_signed_mode <= i_cfg_wdata;
        end
    end

    leb_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .o_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_push_data  (w_push_data)
    );

    leb_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_data  (w_push_data),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_data   (w_pop_data)
    );

    leb_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_signed_mode (r_signed_mode),
        .i_cmd_valid   (w_pop_valid),
        .o_cmd_ready   (w_pop_ready),
        .i_cmd         (w_pop_data),
        .o_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .o_m_tdata     (m_axis_tdata),
        .o_m_tuser     (m_axis_tuser)
    );

    // end-of-buffer command taken by the back
    assign w_end_pop = w_pop_valid && w_pop_ready && (w_pop_data.kind == leb_pkg::CMD_END);

    // the front takes no new byte while a full queue leaves its beat held
    `LEB_ASSERT_IMPLY(a_front_holds_on_full, w_push_valid && !w_push_ready, !s_axis_tready)
    // end-of-buffer command always yields a malformed result next cycle
    `LEB_ASSERT_NEXT(a_end_gives_malformed, w_end_pop, m_axis_tvalid && m_axis_tuser)
    // back never takes a command while a result is stuck
    `LEB_ASSERT_IMPLY(a_back_stalls, m_axis_tvalid && !m_axis_tready, !w_pop_ready)

endmodule
